### src/ipv6t_pkg.sv
// Shared types, constants and helper functions for the IPv6 address to text block.
package ipv6t_pkg;

    localparam int NUM_GROUPS = 8;
    localparam int GRP_IDX_W  = $clog2(NUM_GROUPS);
    localparam int RUN_LEN_W  = $clog2(NUM_GROUPS + 1);
    localparam int NUM_V4_BYTES = 4;

    localparam logic [GRP_IDX_W-1:0] LAST_GRP = GRP_IDX_W'(NUM_GROUPS - 1);
    localparam logic [GRP_IDX_W-1:0] V4_GRP   = GRP_IDX_W'(6);
    localparam logic [RUN_LEN_W-1:0] RUN_END_ALL = RUN_LEN_W'(NUM_GROUPS);

    localparam logic [6:0] CHR_COLON = 7'h3A;
    localparam logic [6:0] CHR_DOT   = 7'h2E;
    localparam logic [6:0] CHR_ZERO  = 7'h30;
    localparam logic [6:0] CHR_LOW_A = 7'h61;

    typedef enum logic [1:0] {
        SEL_HEX   = 2'd0,
        SEL_COLON = 2'd1,
        SEL_DEC   = 2'd2,
        SEL_DOT   = 2'd3
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      scan;
        logic      emit;
        char_sel_t char_sel;
        logic      last;
        logic      g_inc;
        logic      g_run_end;
        logic      d_load;
        logic      d_dec;
        logic      j_clear;
        logic      j_inc;
        logic      p_load;
        logic      p_dec;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic comp_here;
        logic v4_here;
        logic g_first;
        logic g_last;
        logic d_zero;
        logic run_to_end;
        logic p_zero;
        logic j_last;
    } dp_status_t;

    // Lowercase ASCII hex digit for one nibble.
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10) begin
            c = CHR_ZERO + 7'(nib);
        end else begin
            c = CHR_LOW_A + 7'(nib - 4'd10);
        end
        return c;
    endfunction

    // Index of the most significant nonzero nibble, or zero for a zero group.
    function automatic logic [1:0] lead_digit(input logic [15:0] grp);
        logic [1:0] d;
        if (grp[15:12] != 4'd0) begin
            d = 2'd3;
        end else if (grp[11:8] != 4'd0) begin
            d = 2'd2;
        end else if (grp[7:4] != 4'd0) begin
            d = 2'd1;
        end else begin
            d = 2'd0;
        end
        return d;
    endfunction

    // Highest decimal place that is printed for a byte value.
    function automatic logic [1:0] dec_start(input logic [7:0] v);
        logic [1:0] p;
        if (v >= 8'd100) begin
            p = 2'd2;
        end else if (v >= 8'd10) begin
            p = 2'd1;
        end else begin
            p = 2'd0;
        end
        return p;
    endfunction

    // Decimal digits of a byte: hundreds in [11:8], tens in [7:4], units in [3:0].
    function automatic logic [11:0] dec_digits(input logic [7:0] v);
        logic [3:0] h;
        logic [3:0] t;
        logic [7:0] r;
        logic [7:0] u;
        if (v >= 8'd200) begin
            h = 4'd2;
            r = v - 8'd200;
        end else if (v >= 8'd100) begin
            h = 4'd1;
            r = v - 8'd100;
        end else begin
            h = 4'd0;
            r = v;
        end
        t = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (r >= 8'(10 * k)) begin
                t = 4'(k);
            end
        end
        u = r - 8'(t) * 8'd10;
        return {h, t, u[3:0]};
    endfunction

endpackage

### src/ipv6t_ctrl.sv
// Sequencing state machine that walks the groups, separators and dotted bytes.
module ipv6t_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ipv6t_pkg::dp_status_t st,
    output ipv6t_pkg::dp_cmd_t    cmd
);
    import ipv6t_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SCAN  = 9'b000000010,
        ST_START = 9'b000000100,
        ST_HEX   = 9'b000001000,
        ST_COLON = 9'b000010000,
        ST_ZLEAD = 9'b000100000,
        ST_ZCOL  = 9'b001000000,
        ST_DEC   = 9'b010000000,
        ST_DOT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan   = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                // The current group decides between dotted tail, compression and hex.
                if (st.v4_here) begin
                    cmd.j_clear = 1'b1;
                    cmd.p_load  = 1'b1;
                    state_next  = ST_DEC;
                end else if (st.comp_here) begin
                    state_next = st.g_first ? ST_ZLEAD : ST_ZCOL;
                end else begin
                    cmd.d_load = 1'b1;
                    state_next = ST_HEX;
                end
            end
            ST_HEX: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = SEL_HEX;
                    if (st.d_zero) begin
                        if (st.g_last) begin
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            cmd.g_inc  = 1'b1;
                            state_next = ST_COLON;
                        end
                    end else begin
                        cmd.d_dec = 1'b1;
                    end
                end
            end
            ST_COLON: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = SEL_COLON;
                    if (st.v4_here) begin
                        cmd.j_clear = 1'b1;
                        cmd.p_load  = 1'b1;
                        state_next  = ST_DEC;
                    end else if (st.comp_here) begin
                        state_next = ST_ZCOL;
                    end else begin
                        cmd.d_load = 1'b1;
                        state_next = ST_HEX;
                    end
                end
            end
            ST_ZLEAD: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = SEL_COLON;
                    state_next   = ST_ZCOL;
                end
            end
            ST_ZCOL: begin
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.char_sel  = SEL_COLON;
                    cmd.g_run_end = 1'b1;
                    if (st.run_to_end) begin
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.d_load = 1'b1;
                        state_next = ST_HEX;
                    end
                end
            end
            ST_DEC: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = SEL_DEC;
                    if (st.p_zero) begin
                        if (st.j_last) begin
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            cmd.j_inc  = 1'b1;
                            state_next = ST_DOT;
                        end
                    end else begin
                        cmd.p_dec = 1'b1;
                    end
                end
            end
            ST_DOT: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = SEL_DOT;
                    cmd.p_load   = 1'b1;
                    state_next   = ST_DEC;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/ipv6t_dp.sv
// Datapath: address register, zero-run scan, walk counters and output register.
module ipv6t_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipv6t_pkg::dp_cmd_t     cmd,
    output ipv6t_pkg::dp_status_t  st,
    input  logic [127:0]          s_tdata,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);
    import ipv6t_pkg::*;

    logic [127:0]          addr_reg;
    logic [GRP_IDX_W-1:0]  best_pos_reg;
    logic [RUN_LEN_W-1:0]  best_len_reg;
    logic                  mapped_reg;
    logic [GRP_IDX_W-1:0]  g_reg;
    logic [GRP_IDX_W-1:0]  g_next;
    logic [1:0]            d_reg;
    logic [1:0]            d_next;
    logic [1:0]            j_reg;
    logic [1:0]            j_next;
    logic [1:0]            p_reg;
    logic [1:0]            p_next;
    logic                  m_tvalid_reg;
    logic [6:0]            m_char_reg;
    logic                  m_tlast_reg;

    logic [15:0]           grp [NUM_GROUPS];
    logic [7:0]            v4b [NUM_V4_BYTES];
    logic [NUM_GROUPS-1:0] zero_grp;
    logic [RUN_LEN_W-1:0]  run_len [NUM_GROUPS];
    logic [GRP_IDX_W-1:0]  scan_pos;
    logic [RUN_LEN_W-1:0]  scan_len;
    logic                  scan_mapped;
    logic [RUN_LEN_W-1:0]  run_end;
    logic [15:0]           grp_cur;
    logic [3:0]            nib;
    logic [11:0]           bcd;
    logic [3:0]            dec_dig;
    logic [6:0]            char_val;

    // Group 0 sits in the top bits; the dotted tail is the low 32 bits.
    always_comb begin
        for (int i = 0; i < NUM_GROUPS; i++) begin
            grp[i]      = addr_reg[127 - 16 * i -: 16];
            zero_grp[i] = (grp[i] == 16'd0);
        end
        for (int i = 0; i < NUM_V4_BYTES; i++) begin
            v4b[i] = addr_reg[31 - 8 * i -: 8];
        end
    end

    // Length of the zero run starting at each group, then the first longest one.
    always_comb begin
        logic                 brk;
        logic [RUN_LEN_W-1:0] cnt;
        for (int s = 0; s < NUM_GROUPS; s++) begin
            brk = 1'b0;
            cnt = '0;
            for (int t = 0; t < NUM_GROUPS; t++) begin
                if (t >= s && !brk) begin
                    if (zero_grp[t]) begin
                        cnt = cnt + RUN_LEN_W'(1);
                    end else begin
                        brk = 1'b1;
                    end
                end
            end
            run_len[s] = cnt;
        end
        scan_len = '0;
        scan_pos = '0;
        for (int s = 0; s < NUM_GROUPS; s++) begin
            if (run_len[s] > scan_len) begin
                scan_len = run_len[s];
                scan_pos = GRP_IDX_W'(s);
            end
        end
        scan_mapped = (addr_reg[127:48] == 80'd0) && (addr_reg[47:32] == 16'hFFFF);
    end

    assign run_end = RUN_LEN_W'(best_pos_reg) + best_len_reg;

    always_comb begin
        if (cmd.load) begin
            g_next = '0;
        end else if (cmd.g_run_end) begin
            g_next = run_end[GRP_IDX_W-1:0];
        end else if (cmd.g_inc) begin
            g_next = g_reg + GRP_IDX_W'(1);
        end else begin
            g_next = g_reg;
        end

        if (cmd.d_load) begin
            d_next = lead_digit(grp[g_next]);
        end else if (cmd.d_dec) begin
            d_next = d_reg - 2'd1;
        end else begin
            d_next = d_reg;
        end

        if (cmd.j_clear) begin
            j_next = '0;
        end else if (cmd.j_inc) begin
            j_next = j_reg + 2'd1;
        end else begin
            j_next = j_reg;
        end

        if (cmd.p_load) begin
            p_next = dec_start(v4b[j_next]);
        end else if (cmd.p_dec) begin
            p_next = p_reg - 2'd1;
        end else begin
            p_next = p_reg;
        end
    end

    always_comb begin
        grp_cur = grp[g_reg];
        nib     = grp_cur[{d_reg, 2'b00} +: 4];
        bcd     = dec_digits(v4b[j_reg]);
        dec_dig = bcd[{p_reg, 2'b00} +: 4];
        case (cmd.char_sel)
            SEL_HEX:   char_val = hex_char(nib);
            SEL_COLON: char_val = CHR_COLON;
            SEL_DEC:   char_val = CHR_ZERO + 7'(dec_dig);
            SEL_DOT:   char_val = CHR_DOT;
            default:   char_val = CHR_COLON;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= {s_tdata[63:0], s_tdata[127:64]};
        end
        if (cmd.scan) begin
            best_pos_reg <= scan_pos;
            best_len_reg <= scan_len;
            mapped_reg   <= scan_mapped;
        end
        if (cmd.emit) begin
            m_char_reg  <= char_val;
            m_tlast_reg <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_reg        <= '0;
            d_reg        <= '0;
            j_reg        <= '0;
            p_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            g_reg <= g_next;
            d_reg <= d_next;
            j_reg <= j_next;
            p_reg <= p_next;
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign st.out_free   = !m_tvalid_reg || m_tready;
    assign st.comp_here  = (best_len_reg != '0) && (g_reg == best_pos_reg);
    assign st.v4_here    = mapped_reg && (g_reg == V4_GRP);
    assign st.g_first    = (g_reg == '0);
    assign st.g_last     = (g_reg == LAST_GRP);
    assign st.d_zero     = (d_reg == 2'd0);
    assign st.run_to_end = (run_end == RUN_END_ALL);
    assign st.p_zero     = (p_reg == 2'd0);
    assign st.j_last     = (j_reg == 2'(NUM_V4_BYTES - 1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_tlast_reg;

endmodule

### src/ipv6_address_to_text.sv
// Top level of the IPv6 address to text converter.
// After the address transaction, the scan state and the start state come before the first
// character is loaded into the output register; characters then follow one per cycle while
// m_tready is high. An address gives from 2 to 39 characters; the pace is set by the single
// output register, which takes one character per cycle while it is empty or m_tready is high.
// Reset (aresetn low at a clock edge) returns the sequencer to idle and empties the output.
module ipv6_address_to_text (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] addr_high, [127:64] addr_low
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // [6:0] out_char, [7] zero fill
    output logic         m_tlast    // last character of the address
);
    import ipv6t_pkg::*;

    // The controller accepts an address only while idle. After the address is captured,
    // the scan state finds the first longest run of zero groups and the IPv4-mapped
    // prefix, the start state picks how the first group is written, and from then on every
    // cycle in which the output register can take a character produces one.
    dp_cmd_t    cmd;
    dp_status_t st;

    ipv6t_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the address, the scan results, the group, digit, byte and
    // decimal place counters, and the output register that decouples a stalled sink.
    ipv6t_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### src/ipv6t_checker.sv
// Port-level checker for the IPv6 address to text converter, bound to the top level.
module ipv6t_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [7:0]   m_tdata,
    input logic         m_tlast
);
    import ipv6t_pkg::*;

    logic char_ok;
    assign char_ok = (m_tdata[6:0] == CHR_COLON) || (m_tdata[6:0] == CHR_DOT)
        || ((m_tdata[6:0] >= CHR_ZERO) && (m_tdata[6:0] <= CHR_ZERO + 7'd9))
        || ((m_tdata[6:0] >= CHR_LOW_A) && (m_tdata[6:0] <= CHR_LOW_A + 7'd5));

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new address accepted while one is being converted");

    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> char_ok && !m_tdata[7])
        else $error("output character outside the address alphabet");

    a_last_not_dot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[6:0] != CHR_DOT)
        else $error("address text ends in a dot");

endmodule

bind ipv6_address_to_text ipv6t_checker u_ipv6t_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
